### design/zbs_pkg.sv
// Package for the zero-byte suppression codec.
// Holds the group constants, register indexes, state codes and the result struct.
// No dependencies; every module of the block imports it.
package zbs_pkg;

  // Bytes in one group, the literal address width, the count width and the register index width.
  localparam int unsigned GROUP   = 8;
  localparam int unsigned LIT_AW  = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CFG_IW  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_MODE       = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SUPPRESSED = 2'd1;

  // Mode codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Group position that means a flag byte is awaited in decode mode.
  localparam logic [CNT_W-1:0] POS_AWAIT_FLAG = 4'd8;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ENC_FLAG = 6'b000010,
    S_ENC_RD   = 6'b000100,
    S_ENC_LIT  = 6'b001000,
    S_DEC_LIT  = 6'b010000,
    S_DEC_SUP  = 6'b100000
  } seq_state_t;

  // One result handed from the sequencer to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic       eor;
    logic       send_end;
  } zbs_result_t;

endpackage

### design/zbs_lit_ram.sv
// Literal buffer of the codec: eight entries of one byte.
// One write port and one read port with registered read data.
// Depends on zbs_pkg for the address width.
module zbs_lit_ram
  import zbs_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [LIT_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [LIT_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [GROUP];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### design/zbs_out_stage.sv
// Output register of the codec, holding one result while the receiver stalls.
// Reports whether it can take a new result in this cycle.
// Depends on zbs_pkg for the result struct.
module zbs_out_stage
  import zbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  zbs_result_t res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        end_of_run,
  output logic        stream_end
);

  // The register can be loaded when empty or when its request leaves now.
  assign free = !out_valid || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, only changed by a new load.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= res.data;
      end_of_run <= res.eor;
      stream_end <= res.send_end;
    end
  end

endmodule

### design/zero_byte_suppression_codec.sv
// Zero-byte suppression codec, top level: sequencer and stream state.
// Uses zbs_pkg, zbs_lit_ram (literal buffer) and zbs_out_stage (output register).
//
// Usage:
//   Input channel (in_valid, in_stall, data_byte, last_in) takes one byte per
//   request; output channel (out_valid, out_stall, out_byte, end_of_run,
//   stream_end) gives the results. The configuration channel (cfg_valid,
//   cfg_ready, cfg_index, cfg_data) writes mode (index 0) and the
//   suppressed byte (index 1); other indexes are ignored. Write it only while
//   the block is idle. Writing the mode restarts the stream state.
//   Encode: a byte that does not end a group is taken with no result. A
//   byte that ends a group or a stream leads to the flag state, which gives
//   the flag byte; then each literal is read from the buffer memory (read
//   data registered) in a read state and given in a literal state, in turn.
//   Decode: a flag byte is taken in the idle state, a literal is given from a
//   literal state, and each suppressed byte that follows from a suppressed
//   state; at the end of a stream each dropped clear flag bit ahead of the
//   last set bit passes that state with no result; later clear bits are skipped.
//   The input is stalled until all results of the current byte have entered
//   the output register; a stalled receiver holds the sequencer.
//   Reset (rst, synchronous) selects encode with suppressed byte zero and an
//   empty group. No clearing pass is needed.
module zero_byte_suppression_codec
  import zbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              last_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              end_of_run,
  output logic              stream_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_data
);

  seq_state_t        state;
  logic              mode;
  logic [7:0]        sup_byte;
  logic [CNT_W-1:0]  pos;
  logic [7:0]        flag;
  logic [CNT_W-1:0]  count;
  logic [LIT_AW-1:0] k;
  logic [7:0]        byte_q;
  logic              last_q;

  logic              accept;
  logic              cfg_wr;
  logic              out_free;
  logic              emit;
  zbs_result_t       res;
  logic [7:0]        rd_data;

  // Encode helpers.
  logic              hit;
  logic [7:0]        flag_enc;
  logic [CNT_W-1:0]  count_enc;
  logic [CNT_W-1:0]  pos_inc;
  logic              lit_done;

  // Decode helpers.
  logic [7:0]        flag_sh;
  logic              dec_more;
  logic              flag_more;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // Group update for an encoded byte.
  assign hit       = (data_byte == sup_byte);
  assign flag_enc  = hit ? (flag | (8'h80 >> pos[LIT_AW-1:0])) : flag;
  assign count_enc = hit ? count : count + CNT_W'(1);
  assign pos_inc   = pos + CNT_W'(1);
  assign lit_done  = ({1'b0, k} + CNT_W'(1)) == count;

  // Flag shift in decode and whether more suppressed bytes follow it.
  assign flag_sh   = {flag[6:0], 1'b0};
  assign dec_more  = last_q ? (flag_sh != 8'd0) : (flag_sh[7] && !pos_inc[CNT_W-1]);
  assign flag_more = last_in ? (data_byte != 8'd0) : data_byte[7];

  // Result selection for the output register.
  always_comb begin
    emit         = 1'b0;
    res.data     = flag;
    res.eor      = 1'b0;
    res.send_end = 1'b0;
    case (state)
      S_ENC_FLAG: begin
        emit     = out_free;
        res.data = flag;
        res.eor  = (count == '0);
      end
      S_ENC_LIT: begin
        emit     = out_free;
        res.data = rd_data;
        res.eor  = lit_done;
      end
      S_DEC_LIT: begin
        emit     = out_free;
        res.data = byte_q;
        res.eor  = !dec_more;
      end
      S_DEC_SUP: begin
        emit     = out_free && flag[7];
        res.data = sup_byte;
        res.eor  = !dec_more;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    res.send_end = res.eor && last_q;
  end

  // Sequencer and stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= MODE_ENCODE;
      sup_byte <= 8'd0;
      pos      <= '0;
      flag     <= 8'd0;
      count    <= '0;
      k        <= '0;
      last_q   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= last_in;
            byte_q <= data_byte;
            if (mode == MODE_ENCODE) begin
              flag  <= flag_enc;
              count <= count_enc;
              if (pos_inc[CNT_W-1] || last_in) begin
                pos   <= '0;
                state <= S_ENC_FLAG;
              end else begin
                pos <= pos_inc;
              end
            end else if (pos[CNT_W-1]) begin
              // A new flag byte.
              if (flag_more) begin
                flag  <= data_byte;
                pos   <= '0;
                state <= S_DEC_SUP;
              end else if (last_in) begin
                flag <= 8'd0;
                pos  <= POS_AWAIT_FLAG;
              end else begin
                flag <= data_byte;
                pos  <= '0;
              end
            end else begin
              state <= S_DEC_LIT;
            end
          end
        end
        S_ENC_FLAG: begin
          if (emit) begin
            if (count == '0) begin
              flag  <= 8'd0;
              state <= S_IDLE;
            end else begin
              k     <= '0;
              state <= S_ENC_RD;
            end
          end
        end
        S_ENC_RD: begin
          state <= S_ENC_LIT;
        end
        S_ENC_LIT: begin
          if (emit) begin
            if (lit_done) begin
              flag  <= 8'd0;
              count <= '0;
              state <= S_IDLE;
            end else begin
              k     <= k + LIT_AW'(1);
              state <= S_ENC_RD;
            end
          end
        end
        S_DEC_LIT, S_DEC_SUP: begin
          // A clear bit at the end of a stream is dropped without a result.
          if (emit || (state == S_DEC_SUP && !flag[7])) begin
            if (dec_more || !emit) begin
              flag  <= flag_sh;
              pos   <= pos_inc;
              state <= S_DEC_SUP;
            end else begin
              if (last_q) begin
                flag <= 8'd0;
                pos  <= POS_AWAIT_FLAG;
              end else begin
                flag <= flag_sh;
                pos  <= pos_inc;
              end
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes; a mode write restarts the stream.
      if (cfg_wr) begin
        case (cfg_index)
          REG_MODE: begin
            mode  <= cfg_data[0];
            pos   <= (cfg_data[0] == MODE_DECODE) ? POS_AWAIT_FLAG : '0;
            flag  <= 8'd0;
            count <= '0;
          end
          REG_SUPPRESSED: begin
            sup_byte <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Literal buffer.
  zbs_lit_ram u_lit_ram (
    .clk     (clk),
    .wr_en   (accept && (mode == MODE_ENCODE) && !hit),
    .wr_addr (count[LIT_AW-1:0]),
    .wr_data (data_byte),
    .rd_addr (k),
    .rd_data (rd_data)
  );

  // Output register.
  zbs_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (emit),
    .res        (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .end_of_run (end_of_run),
    .stream_end (stream_end)
  );

  // A group never holds more than eight literals.
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(GROUP))
    else $error("literal count beyond one group");

  // The group position never passes the flag-await value.
  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    pos <= POS_AWAIT_FLAG)
    else $error("group position out of range");

  // The end of a stream is always the last result of its byte.
  a_end_marks : assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> end_of_run)
    else $error("stream end without end of run");

  // A result is loaded only while the sequencer is busy with an item.
  a_emit_busy : assert property (@(posedge clk) disable iff (rst)
    emit |-> in_stall)
    else $error("result loaded while idle");

endmodule
